FILE: rtl/core/rksm_pkg.sv
package rksm_pkg;

  localparam int HASH_W  = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_HASH     = 1'b0,
    KIND_POSITION = 1'b1
  } report_kind_t;

  typedef struct packed {
    logic clear;
    logic step;
  } hash_ctl_t;

  // base-4 digits each weigh 1 modulo 3
  function automatic logic [1:0] digit_of(input logic [7:0] b);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(b[7:6]) + 4'(b[5:4]) + 4'(b[3:2]) + 4'(b[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

FILE: rtl/core/rabin_karp_stream_matcher_core.sv
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+-----------------------------------------
// text      | in        | text_valid / text_ready  | text_byte
// report    | out       | report_valid/report_ready| report_kind, report_value, last_of_run
// cfg       | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Each byte runs these steps (n = pattern length in use): one to shift the window,
// n steps of the shared multiply-by-three-and-add unit, one to compare the hashes.
// A hash hit adds the position beats; the first byte adds the hash beat.
// Reset is synchronous; it clears the window state, sets length 1 and zero pattern.
// A stalled report beat holds the sequencer; text_ready is low until it resumes.
module rabin_karp_stream_matcher_core
  import rksm_pkg::*;
#(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_ready,
  input  logic [7:0]           text_byte,
  output logic                 report_valid,
  input  logic                 report_ready,
  output logic                 report_kind,
  output logic [31:0]          report_value,
  output logic                 last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_REPORT_HASH,
    ST_VERIFY
  } state_t;

  state_t                   state;
  logic [4:0]               pattern_length;
  logic [CFG_W-1:0]         pattern_low;
  logic [CFG_W-1:0]         pattern_high;
  logic [7:0]               window_bytes [MAX_PATTERN];
  logic [LEN_W-1:0]         fill_count;
  logic [POSITION_BITS-1:0] window_start;
  logic                     hash_reported;
  logic                     hit;
  logic [LEN_W-1:0]         cnt;

  logic [LEN_W-1:0]         used_len;
  logic [IDX_W-1:0]         win_idx;
  logic [3:0]               pat_idx;
  logic [2*CFG_W-1:0]       pattern_all;
  logic [7:0]               pat_byte;
  logic [7:0]               win_byte;
  logic                     out_free;
  logic                     report_load;
  logic                     text_beat;
  logic [POSITION_BITS-1:0] position;
  hash_ctl_t                hctl;
  logic [HASH_W-1:0]        pattern_hash;
  logic                     hash_equal;

  always_comb begin
    if (pattern_length == 5'd0) begin
      used_len = LEN_W'(1);
    end else if (pattern_length > 5'(MAX_PATTERN)) begin
      used_len = LEN_W'(MAX_PATTERN);
    end else begin
      used_len = LEN_W'(pattern_length);
    end
  end

  assign win_idx     = IDX_W'(MAX_PATTERN - int'(used_len) + int'(cnt));
  assign pat_idx     = 4'(cnt);
  assign pattern_all = {pattern_high, pattern_low};
  assign pat_byte    = pattern_all[pat_idx*8 +: 8];
  assign win_byte    = window_bytes[win_idx];
  assign out_free    = !report_valid || report_ready;
  assign report_load = out_free && ((state == ST_REPORT_HASH) || (state == ST_VERIFY));
  assign text_ready  = (state == ST_IDLE);
  assign text_beat   = text_valid && text_ready;
  assign cfg_ready   = 1'b1;
  assign position    = window_start + POSITION_BITS'(cnt) + POSITION_BITS'(1);

  assign hctl.clear = text_beat;
  assign hctl.step  = (state == ST_HASH);

  rksm_hash_unit u_hash (
    .clk           (clk),
    .ctl           (hctl),
    .pattern_digit (digit_of(pat_byte)),
    .window_digit  (digit_of(win_byte)),
    .pattern_hash  (pattern_hash),
    .hash_equal    (hash_equal)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_bytes[k] <= '0;
      end
    end else if (text_beat) begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        window_bytes[k] <= window_bytes[k+1];
      end
      window_bytes[MAX_PATTERN-1] <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pattern_length <= 5'd1;
      pattern_low    <= '0;
      pattern_high   <= '0;
      fill_count     <= '0;
      window_start   <= '0;
      hash_reported  <= 1'b0;
      hit            <= 1'b0;
      cnt            <= '0;
      report_valid   <= 1'b0;
      report_kind    <= 1'b0;
      report_value   <= '0;
      last_of_run    <= 1'b0;
    end else begin
      if (report_valid && report_ready && !report_load) begin
        report_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
          REG_PATTERN_LOW:    pattern_low    <= cfg_data;
          REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (text_beat) begin
            if (fill_count >= used_len) begin
              window_start <= window_start + POSITION_BITS'(1);
            end
            if (fill_count < LEN_W'(MAX_PATTERN)) begin
              fill_count <= fill_count + LEN_W'(1);
            end
            cnt   <= used_len - LEN_W'(1);
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (cnt == '0) begin
            state <= ST_CHECK;
          end else begin
            cnt <= cnt - LEN_W'(1);
          end
        end
        ST_CHECK: begin
          hit <= (fill_count >= used_len) && hash_equal;
          cnt <= '0;
          if (!hash_reported) begin
            state <= ST_REPORT_HASH;
          end else if ((fill_count >= used_len) && hash_equal) begin
            state <= ST_VERIFY;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_REPORT_HASH: begin
          if (out_free) begin
            report_valid  <= 1'b1;
            report_kind   <= KIND_HASH;
            report_value  <= 32'(pattern_hash);
            last_of_run   <= !hit;
            hash_reported <= 1'b1;
            state         <= hit ? ST_VERIFY : ST_IDLE;
          end
        end
        ST_VERIFY: begin
          if (out_free) begin
            report_valid <= 1'b1;
            report_kind  <= KIND_POSITION;
            report_value <= 32'(position);
            // stop after the last position or at the first byte mismatch
            if ((cnt == used_len - LEN_W'(1)) || (pat_byte != win_byte)) begin
              last_of_run <= 1'b1;
              state       <= ST_IDLE;
            end else begin
              last_of_run <= 1'b0;
              cnt         <= cnt + LEN_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/rksm_hash_unit.sv
module rksm_hash_unit
  import rksm_pkg::*;
(
  input  logic              clk,
  input  hash_ctl_t         ctl,
  input  logic [1:0]        pattern_digit,
  input  logic [1:0]        window_digit,
  output logic [HASH_W-1:0] pattern_hash,
  output logic              hash_equal
);

  logic [HASH_W-1:0] pattern_acc;
  logic [HASH_W-1:0] window_acc;

  // Horner step, most significant digit first
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      pattern_acc <= '0;
      window_acc  <= '0;
    end else if (ctl.step) begin
      pattern_acc <= (pattern_acc << 1) + pattern_acc + HASH_W'(pattern_digit);
      window_acc  <= (window_acc << 1) + window_acc + HASH_W'(window_digit);
    end
  end

  assign pattern_hash = pattern_acc;
  assign hash_equal   = (pattern_acc == window_acc);

endmodule
